// ===== design/hbid_pkg.sv =====
// Package for the hierarchical bitmap id allocator.
// Holds request and response types, operation and status codes and sizing constants.
// No dependencies.
package hbid_pkg;

  // Fixed layout: 64 ids per leaf word, request ids up to 12 bits
  localparam int GROUP_BITS   = 6;
  localparam int GROUP_SIZE   = 1 << GROUP_BITS;
  localparam int REQ_ID_W     = 12;
  localparam int COUNT_W      = 13;
  localparam int ID_BITS_DEF  = 12;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_STATE   = 2'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic [REQ_ID_W-1:0] req_id;
  } hbid_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [REQ_ID_W-1:0] result_id;
    logic                busy_res;
  } hbid_rsp_t;

endpackage

// ===== design/hbid_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/hbid_ffz.sv =====
// Find-first-zero unit: lowest clear bit of a 64-bit word, shared by both bitmap levels.
// Depends on hbid_pkg for the group size.
module hbid_ffz (
  input  logic [hbid_pkg::GROUP_SIZE-1:0] word,
  output logic                            found,
  output logic [hbid_pkg::GROUP_BITS-1:0] idx
);

  logic [7:0]       byte_hit;
  logic [7:0][2:0]  byte_idx;

  // Search each byte for its lowest clear bit
  always_comb begin
    byte_hit = '0;
    byte_idx = '0;
    for (int g = 0; g < 8; g++) begin
      for (int b = 7; b >= 0; b--) begin
        if (!word[g*8 + b]) begin
          byte_hit[g] = 1'b1;
          byte_idx[g] = 3'(b);
        end
      end
    end
  end

  // Pick the lowest byte that holds a clear bit
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int g = 7; g >= 0; g--) begin
      if (byte_hit[g]) begin
        found = 1'b1;
        idx   = {3'(g), byte_idx[g]};
      end
    end
  end

endmodule

// ===== design/hierarchical_bitmap_id_allocator.sv =====
// Hierarchical bitmap id allocator: top level.
// Depends on hbid_pkg, hbid_ram and hbid_ffz.
//
// Allocates, claims, frees and queries ids 0 .. 2^ID_BITS-1 held in a two-level
// busy bitmap: a RAM of 64-bit leaf words and a register of summary bits, one per
// full leaf word. Allocate runs through summary search, leaf search and update and
// response load, the other operations through leaf check and update and response
// load. in_ready returns the cycle after the response loads. The registered leaf
// RAM read and the single shared find-first-zero unit keep these steps in sequence.
// in_ready is high only while no request is in progress; a finished response waits
// in the output register while the next request is accepted and runs up to its
// response stage, where it waits for the register to empty. Leaf words read as zero
// until first written, tracked by one valid bit per word, so no clearing pass
// follows reset. cfg_wdata sets the number of ids in use (reset 4096) and must only
// be written while the block is idle.
module hierarchical_bitmap_id_allocator #(
  parameter int ID_BITS = hbid_pkg::ID_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  hbid_pkg::hbid_req_t                in_req,
  output logic                               out_valid,
  input  logic                               out_ready,
  output hbid_pkg::hbid_rsp_t                out_rsp,
  input  logic                               cfg_we,
  input  logic [hbid_pkg::COUNT_W-1:0]       cfg_wdata
);

  localparam int GB         = hbid_pkg::GROUP_BITS;
  localparam int GS         = hbid_pkg::GROUP_SIZE;
  localparam int WB         = ID_BITS - GB;
  localparam int LEAF_WORDS = 1 << WB;
  localparam int WIDX_W     = (WB > 0) ? WB : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_LEAF = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [hbid_pkg::COUNT_W-1:0]    id_count_r;
  logic [LEAF_WORDS-1:0]           summary_r;
  logic [LEAF_WORDS-1:0]           vld_r;
  logic [1:0]                      op_r;
  logic [ID_BITS-1:0]              rid_r;
  logic [WIDX_W-1:0]               rd_addr_r;
  logic                            sum_found_r;
  hbid_pkg::hbid_rsp_t             res_r, res_nxt;
  logic                            out_valid_r;
  hbid_pkg::hbid_rsp_t             out_rsp_r;

  logic                            in_fire;
  logic [ID_BITS-1:0]              in_rid;
  logic [WIDX_W-1:0]               rd_addr;
  logic [GS-1:0]                   rd_data;
  logic [GS-1:0]                   leaf_word;
  logic [GS-1:0]                   sum_word;
  logic [GS-1:0]                   ffz_word;
  logic                            ffz_found;
  logic [GB-1:0]                   ffz_idx;
  logic [GB-1:0]                   bit_pos;
  logic                            bit_busy;
  logic [WIDX_W+GB-1:0]            cand_full;
  logic [ID_BITS-1:0]              cand_id;
  logic                            rid_in_range;
  logic                            do_set;
  logic                            do_clr;
  logic [GS-1:0]                   wr_word;
  logic                            out_load;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_rid   = in_req.req_id[ID_BITS-1:0];

  // Summary bits padded with busy for words that do not exist
  always_comb begin
    sum_word = '1;
    sum_word[LEAF_WORDS-1:0] = summary_r;
  end

  // Leaf words never written read as all free
  assign leaf_word = vld_r[rd_addr_r] ? rd_data : '0;

  // Shared search unit: summary in S_SUM, leaf word otherwise
  assign ffz_word = (state_r == S_SUM) ? sum_word : leaf_word;

  hbid_ffz u_ffz (
    .word  (ffz_word),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  // Leaf read address: requested word on accept, found word after summary search
  assign rd_addr = (state_r == S_SUM) ? ffz_idx[WIDX_W-1:0]
                                      : WIDX_W'(in_rid >> GB);

  // Candidate id and range checks
  assign cand_full    = {rd_addr_r, ffz_idx};
  assign cand_id      = cand_full[ID_BITS-1:0];
  assign rid_in_range = hbid_pkg::COUNT_W'(rid_r) < id_count_r;
  assign bit_pos      = (op_r == hbid_pkg::OP_ALLOC) ? ffz_idx : rid_r[GB-1:0];
  assign bit_busy     = leaf_word[bit_pos];

  // Decide the response and any bitmap update
  always_comb begin
    res_nxt           = '0;
    res_nxt.result_id = hbid_pkg::REQ_ID_W'(rid_r);
    do_set            = 1'b0;
    do_clr            = 1'b0;
    if (op_r == hbid_pkg::OP_ALLOC) begin
      if (!sum_found_r || !ffz_found ||
          hbid_pkg::COUNT_W'(cand_id) >= id_count_r) begin
        res_nxt.status    = hbid_pkg::ST_NO_FREE;
        res_nxt.result_id = '0;
      end else begin
        res_nxt.status    = hbid_pkg::ST_OK;
        res_nxt.result_id = hbid_pkg::REQ_ID_W'(cand_id);
        do_set            = 1'b1;
      end
    end else if (!rid_in_range) begin
      res_nxt.status = hbid_pkg::ST_RANGE;
    end else begin
      unique case (op_r)
        hbid_pkg::OP_MARK: begin
          if (bit_busy) res_nxt.status = hbid_pkg::ST_STATE;
          else          do_set = 1'b1;
        end
        hbid_pkg::OP_FREE: begin
          if (!bit_busy) res_nxt.status = hbid_pkg::ST_STATE;
          else           do_clr = 1'b1;
        end
        default: begin
          res_nxt.busy_res = bit_busy;
        end
      endcase
    end
  end

  // New leaf word
  always_comb begin
    wr_word = leaf_word;
    if (do_set) wr_word[bit_pos] = 1'b1;
    if (do_clr) wr_word[bit_pos] = 1'b0;
  end

  hbid_ram #(
    .WIDTH (GS),
    .DEPTH (LEAF_WORDS),
    .AW    (WIDX_W)
  ) u_leaf_ram (
    .clk     (clk),
    .wr_en   ((state_r == S_LEAF) && (do_set || do_clr)),
    .wr_addr (rd_addr_r),
    .wr_data (wr_word),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_req.op == hbid_pkg::OP_ALLOC) ? S_SUM : S_LEAF;
        end
      end
      S_SUM:  state_nxt = S_LEAF;
      S_LEAF: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state: sequencer, count, summary, valid bits, output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      id_count_r  <= hbid_pkg::COUNT_RESET;
      summary_r   <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) id_count_r <= cfg_wdata;
      // Update summary and mark the word written
      if (state_r == S_LEAF && (do_set || do_clr)) begin
        vld_r[rd_addr_r] <= 1'b1;
        if (do_clr)               summary_r[rd_addr_r] <= 1'b0;
        else if (&wr_word)        summary_r[rd_addr_r] <= 1'b1;
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
    if (in_fire) begin
      op_r  <= in_req.op;
      rid_r <= in_rid;
    end
    // Hold the summary search outcome
    if (state_r == S_SUM) sum_found_r <= ffz_found;
    else if (in_fire)     sum_found_r <= 1'b0;
    if (state_r == S_LEAF) res_r <= res_nxt;
    if (out_load)          out_rsp_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
